FILE: rtl/deq_pkg.sv
package deq_pkg;

  localparam int WORD_W = 32;

  // action codes
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_SIZE       = 3'd4;
  localparam logic [2:0] ACT_EMPTY      = 3'd5;
  localparam logic [2:0] ACT_FRONT      = 3'd6;
  localparam logic [2:0] ACT_BACK       = 3'd7;

  localparam logic signed [WORD_W-1:0] MINUS_ONE = -32'sd1;

  typedef struct packed {
    logic we;
    logic re;
  } deq_mem_ctl_t;

endpackage

FILE: rtl/deq_ram.sv
module deq_ram
  import deq_pkg::*;
#(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  deq_mem_ctl_t             ctl,
  input  logic [AW-1:0]            addr,
  input  logic signed [WORD_W-1:0] wdata,
  output logic signed [WORD_W-1:0] rdata
);

  logic signed [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: rtl/deq_ctrl.sv
module deq_ctrl
  import deq_pkg::*;
#(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = AW + 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               action,
  input  logic signed [WORD_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [WORD_W-1:0] reply,
  output logic                     was_empty,
  output deq_mem_ctl_t             mem_ctl,
  output logic [AW-1:0]            mem_addr,
  output logic signed [WORD_W-1:0] mem_wdata,
  input  logic signed [WORD_W-1:0] mem_rdata
);

  logic [AW-1:0] front;
  logic [CW-1:0] count;
  logic          pending;
  logic          pend_mem;
  logic signed [WORD_W-1:0] pend_reply;
  logic          pend_empty;

  logic [AW-1:0] front_next;
  logic [CW-1:0] count_next;
  logic          accept;
  logic          is_full;
  logic          is_empty;
  logic [AW-1:0] front_dec;
  logic [AW-1:0] front_inc;
  logic [CW-1:0] back_sum;
  logic [CW-1:0] push_sum;
  logic [AW-1:0] back_pos;
  logic [AW-1:0] push_pos;
  logic          load_out;
  logic          res_valid;
  logic          res_mem;
  logic signed [WORD_W-1:0] res_reply;
  logic          res_empty;

  assign in_ready = !pending;
  assign accept   = in_valid && in_ready;
  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);

  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - 1'b1;
  assign front_inc = (front == AW'(DEPTH - 1)) ? '0 : front + 1'b1;

  // positions wrap once at most since both terms stay below DEPTH
  assign back_sum = {1'b0, front} + (count - 1'b1);
  assign push_sum = {1'b0, front} + count;
  assign back_pos = (back_sum >= CW'(DEPTH)) ? AW'(back_sum - CW'(DEPTH)) : back_sum[AW-1:0];
  assign push_pos = (push_sum >= CW'(DEPTH)) ? AW'(push_sum - CW'(DEPTH)) : push_sum[AW-1:0];

  assign mem_wdata = value;

  always_comb begin
    front_next = front;
    count_next = count;
    mem_ctl    = '0;
    mem_addr   = front;
    res_valid  = 1'b0;
    res_mem    = 1'b0;
    res_reply  = MINUS_ONE;
    res_empty  = 1'b1;
    if (accept) begin
      unique case (action)
        ACT_PUSH_FRONT: begin
          if (!is_full) begin
            front_next = front_dec;
            count_next = count + 1'b1;
            mem_ctl.we = 1'b1;
            mem_addr   = front_dec;
          end
        end
        ACT_PUSH_BACK: begin
          if (!is_full) begin
            count_next = count + 1'b1;
            mem_ctl.we = 1'b1;
            mem_addr   = push_pos;
          end
        end
        ACT_POP_FRONT, ACT_FRONT: begin
          res_valid = 1'b1;
          if (!is_empty) begin
            mem_ctl.re = 1'b1;
            mem_addr   = front;
            res_mem    = 1'b1;
            res_empty  = 1'b0;
            if (action == ACT_POP_FRONT) begin
              front_next = front_inc;
              count_next = count - 1'b1;
            end
          end
        end
        ACT_POP_BACK, ACT_BACK: begin
          res_valid = 1'b1;
          if (!is_empty) begin
            mem_ctl.re = 1'b1;
            mem_addr   = back_pos;
            res_mem    = 1'b1;
            res_empty  = 1'b0;
            if (action == ACT_POP_BACK) begin
              count_next = count - 1'b1;
            end
          end
        end
        ACT_SIZE: begin
          res_valid = 1'b1;
          res_reply = WORD_W'(count);
          res_empty = 1'b0;
        end
        ACT_EMPTY: begin
          res_valid = 1'b1;
          res_reply = is_empty ? 32'sd1 : 32'sd0;
          res_empty = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // pending result moves to the output register once it is free
  assign load_out = pending && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      count     <= '0;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      front <= front_next;
      count <= count_next;
      if (load_out) begin
        pending   <= 1'b0;
        out_valid <= 1'b1;
      end else begin
        if (res_valid) begin
          pending <= 1'b1;
        end
        if (out_ready) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      pend_mem   <= res_mem;
      pend_reply <= res_reply;
      pend_empty <= res_empty;
    end
    if (load_out) begin
      reply     <= pend_mem ? mem_rdata : pend_reply;
      was_empty <= pend_empty;
    end
  end

endmodule

FILE: rtl/double_ended_queue_top.sv
// channel  dir  handshake              fields
// in       in   in_valid / in_ready    action[2:0], value[31:0]
// out      out  out_valid / out_ready  reply[31:0], was_empty
//
// a push yields no result; pop, peek, size and empty wait in the pending register
// beside the registered ring memory read, then load the output register when free
// one item at a time: in_ready drops while a result waits for the output register
// the output register lets a new beat in while the previous result is still held
// reset clears front index, count and handshake state; memory content is not cleared
module double_ended_queue_top
  import deq_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               action,
  input  logic signed [WORD_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [WORD_W-1:0] reply,
  output logic                     was_empty
);

  localparam int AW = $clog2(DEPTH);

  deq_mem_ctl_t             mem_ctl;
  logic [AW-1:0]            mem_addr;
  logic signed [WORD_W-1:0] mem_wdata;
  logic signed [WORD_W-1:0] mem_rdata;

  deq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .reply     (reply),
    .was_empty (was_empty),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  deq_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mem_ctl.we && mem_ctl.re))
    else $error("ring memory read and write in the same cycle");

  a_push_no_stall: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (action == ACT_PUSH_FRONT || action == ACT_PUSH_BACK))
    |=> in_ready)
    else $error("push left a result pending");

  a_read_holds_input: assert property (@(posedge clk) disable iff (rst)
    mem_ctl.re |=> !in_ready)
    else $error("input taken while a read result is outstanding");

  a_empty_reply: assert property (@(posedge clk) disable iff (rst)
    (out_valid && was_empty) |-> (reply == MINUS_ONE))
    else $error("empty flag without minus one reply");

endmodule
